[hdl/bt2b_pkg.sv]
package bt2b_pkg;

   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_BS    = 8'h5c;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_L     = 8'h6c;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_F     = 8'h66;

   localparam logic [5:0] RESULT_LIMIT = 6'd32;

   typedef struct packed {
      logic lt;
      logic bs;
      logic gt;
      logic colon;
      logic minus;
      logic digit;
      logic hexl;
      logic typ;
      logic fmt;
   } cls_type;

   typedef struct packed {
      logic [7:0] ch;
      cls_type    cls;
      logic       eot;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_TOKEN,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      K_NONE,
      K_LIT,
      K_ESC_LIT,
      K_ESC_REPLAY,
      K_ESC_SET,
      K_OPEN,
      K_APPEND,
      K_TOKEN,
      K_FAIL,
      K_FLUSH_ESC,
      K_FLUSH_FAIL
   } kind_type;

   function automatic cls_type classify(input logic [7:0] ch);
      cls_type c;
      c.lt    = (ch == CH_LT);
      c.bs    = (ch == CH_BS);
      c.gt    = (ch == CH_GT);
      c.colon = (ch == CH_COLON);
      c.minus = (ch == CH_MINUS);
      c.digit = (ch >= CH_0) && (ch <= CH_9);
      c.hexl  = (ch >= CH_A) && (ch <= CH_F);
      c.typ   = (ch == CH_B) || (ch == CH_W) || (ch == CH_L);
      c.fmt   = (ch == CH_D) || (ch == CH_H);
      return c;
   endfunction

endpackage

[hdl/bt2b_chan_if.sv]
interface bt2b_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       end_of_text;
   modport source (output valid, output text_char, output end_of_text, input ready);
   modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface bt2b_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;
   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

interface bt2b_csr_if;
   logic valid;
   logic ready;
   logic endian_mode;
   modport source (output valid, output endian_mode, input ready);
   modport sink (input valid, input endian_mode, output ready);
endinterface

[hdl/bytecode_text_to_binary_core.sv]
// Output path: each byte waits in a holding register until the next byte or the end of
// the request decides its last flag, then moves to the registered response outputs.
// Per character the engine steps through pop, read, execute, end check and done, with extra
// steps for rescans, token bytes and unknown escapes; it pops the next character only when idle.
// Reset: synchronous, active high; clears the queue, token length, escape flag and
// endian mode. The character window needs no clearing.
module bytecode_text_to_binary_core
   import bt2b_pkg::*;
#(
   parameter int MAX_TOKEN = 32
) (
   input  logic         clock,
   input  logic         reset,
   bt2b_req_if.sink     req_ch,
   bt2b_rsp_if.source   rsp_ch,
   bt2b_csr_if.sink     csr_ch
);

   logic            endian_ff;
   queue_head_type  head;
   logic            pop;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         endian_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         endian_ff <= csr_ch.endian_mode;
      end
   end

   bt2b_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   bt2b_engine #(
      .MAX_TOKEN (MAX_TOKEN)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .endian_mode (endian_ff),
      .head        (head),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

   a_full_stalls_req: assert property (@(posedge clock) disable iff (reset)
      (head.valid && !pop && !req_ch.ready) |=> head.valid)
      else $error("queue lost an entry");

endmodule

[hdl/bt2b_front.sv]
module bt2b_front
   import bt2b_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   bt2b_req_if.sink          req_ch,
   output queue_head_type    head,
   input  logic              pop
);

   item_type   ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign head.valid   = (count_ff != 2'd0);
   assign head.item    = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= '{ch: req_ch.text_char, cls: classify(req_ch.text_char),
                                eot: req_ch.end_of_text};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/bt2b_engine.sv]
module bt2b_engine
   import bt2b_pkg::*;
#(
   parameter int MAX_TOKEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              endian_mode,
   input  queue_head_type    head,
   output logic              pop,
   bt2b_rsp_if.source        rsp_ch
);

   localparam int AW = $clog2(MAX_TOKEN) + 1;
   localparam int LW = $clog2(MAX_TOKEN + 1);

   item_type        mem [2**AW];
   item_type        rd_ff;

   state_type       state_ff, state_in;
   kind_type        kind;
   logic [AW-1:0]   scan_ff, scan_in, start_ff, start_in, end_ff, end_in;
   logic [LW-1:0]   len_ff, len_in;
   logic            esc_ff, esc_in, eot_ff, eot_in;
   logic [7:0]      type_ff, type_in;
   logic            dec_ff, dec_in, neg_ff, neg_in, stop_ff, stop_in;
   logic [31:0]     val_ff, val_in;
   logic [1:0]      k_ff, k_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic            hold_v_ff, hold_v_in;
   logic [7:0]      hold_b_ff, hold_b_in;
   logic            rsp_v_ff, rsp_v_in, rsp_l_ff, rsp_l_in;
   logic [7:0]      rsp_b_ff, rsp_b_in;

   logic            emit_req, emit_ok, stall, rsp_free, ok;
   logic [7:0]      emit_byte, tok_byte;
   logic [1:0]      nb_m1, idx;
   logic [3:0]      hexd;

   assign rsp_ch.valid     = rsp_v_ff;
   assign rsp_ch.out_byte  = rsp_b_ff;
   assign rsp_ch.last_byte = rsp_l_ff;

   assign rsp_free = !rsp_v_ff || rsp_ch.ready;
   assign emit_ok  = !hold_v_ff || rsp_free;
   assign stall    = emit_req && !emit_ok;
   assign pop      = (state_ff == ST_IDLE) && head.valid;
   assign hexd     = rd_ff.cls.digit ? rd_ff.ch[3:0] : rd_ff.ch[3:0] + 4'd9;

   always_comb begin
      if (type_ff == CH_B) begin
         nb_m1 = 2'd0;
      end else if (type_ff == CH_W) begin
         nb_m1 = 2'd1;
      end else begin
         nb_m1 = 2'd3;
      end
      idx = endian_mode ? nb_m1 - k_ff : k_ff;
      case (idx)
         2'd0:    tok_byte = val_ff[7:0];
         2'd1:    tok_byte = val_ff[15:8];
         2'd2:    tok_byte = val_ff[23:16];
         default: tok_byte = val_ff[31:24];
      endcase
   end

   // classify the current step
   always_comb begin
      kind      = K_NONE;
      emit_req  = 1'b0;
      emit_byte = rd_ff.ch;
      ok        = 1'b0;
      unique case (state_ff)
         ST_READ: begin
            if (scan_ff == end_ff) begin
               if (eot_ff && esc_ff) begin
                  kind      = K_FLUSH_ESC;
                  emit_req  = 1'b1;
                  emit_byte = CH_BS;
               end else if (eot_ff && (len_ff != '0)) begin
                  kind      = K_FLUSH_FAIL;
                  emit_req  = 1'b1;
                  emit_byte = CH_LT;
               end
            end
         end
         ST_EXEC: begin
            if (esc_ff) begin
               emit_req = 1'b1;
               if (rd_ff.cls.lt || rd_ff.cls.bs) begin
                  kind = K_ESC_LIT;
               end else begin
                  kind      = K_ESC_REPLAY;
                  emit_byte = CH_BS;
               end
            end else if (len_ff == '0) begin
               if (rd_ff.cls.lt) begin
                  kind = K_OPEN;
               end else if (rd_ff.cls.bs) begin
                  kind = K_ESC_SET;
               end else begin
                  kind     = K_LIT;
                  emit_req = 1'b1;
               end
            end else begin
               if (len_ff == LW'(1)) begin
                  ok = rd_ff.cls.typ;
               end else if (len_ff == LW'(2)) begin
                  ok = rd_ff.cls.fmt;
               end else if (len_ff == LW'(3)) begin
                  ok = rd_ff.cls.colon;
               end else begin
                  ok = dec_ff ? (rd_ff.cls.digit || rd_ff.cls.minus)
                              : (rd_ff.cls.digit || rd_ff.cls.hexl);
                  if (len_ff >= LW'(MAX_TOKEN - 1)) begin
                     ok = 1'b0;
                  end
               end
               if ((len_ff > LW'(4)) && rd_ff.cls.gt) begin
                  kind = K_TOKEN;
               end else if (ok) begin
                  kind = K_APPEND;
               end else begin
                  kind      = K_FAIL;
                  emit_req  = 1'b1;
                  emit_byte = CH_LT;
               end
            end
         end
         ST_TOKEN: begin
            emit_req  = 1'b1;
            emit_byte = tok_byte;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (scan_ff != end_ff) begin
               state_in = ST_EXEC;
            end else if (kind == K_NONE) begin
               state_in = ST_DONE;
            end
         end
         ST_EXEC: begin
            if (!stall) begin
               if (kind == K_TOKEN) begin
                  state_in = ST_TOKEN;
               end else if (kind != K_ESC_REPLAY) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_TOKEN: begin
            if (!stall && (k_ff == nb_m1)) begin
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!hold_v_ff || rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      scan_in   = scan_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      len_in    = len_ff;
      esc_in    = esc_ff;
      eot_in    = eot_ff;
      type_in   = type_ff;
      dec_in    = dec_ff;
      neg_in    = neg_ff;
      stop_in   = stop_ff;
      val_in    = val_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      hold_v_in = hold_v_ff;
      hold_b_in = hold_b_ff;
      rsp_v_in  = rsp_v_ff && !rsp_ch.ready;
      rsp_b_in  = rsp_b_ff;
      rsp_l_in  = rsp_l_ff;

      if (pop) begin
         end_in = end_ff + AW'(1);
         eot_in = head.item.eot;
         cnt_in = '0;
      end

      // emit: older held byte moves out, new byte is held until the next decides last
      if (emit_req && !stall && (cnt_ff != RESULT_LIMIT)) begin
         if (hold_v_ff) begin
            rsp_v_in = 1'b1;
            rsp_b_in = hold_b_ff;
            rsp_l_in = 1'b0;
         end
         hold_v_in = 1'b1;
         hold_b_in = emit_byte;
         cnt_in    = cnt_ff + 6'd1;
      end

      if ((state_ff == ST_DONE) && hold_v_ff && rsp_free) begin
         rsp_v_in  = 1'b1;
         rsp_b_in  = hold_b_ff;
         rsp_l_in  = 1'b1;
         hold_v_in = 1'b0;
      end

      if (state_ff == ST_TOKEN && !stall) begin
         k_in = k_ff + 2'd1;
      end

      if (!stall) begin
         case (kind)
            K_LIT, K_ESC_LIT: begin
               scan_in = scan_ff + AW'(1);
               esc_in  = 1'b0;
            end
            K_ESC_REPLAY, K_FLUSH_ESC: begin
               esc_in = 1'b0;
            end
            K_ESC_SET: begin
               scan_in = scan_ff + AW'(1);
               esc_in  = 1'b1;
            end
            K_OPEN: begin
               start_in = scan_ff;
               scan_in  = scan_ff + AW'(1);
               len_in   = LW'(1);
               neg_in   = 1'b0;
               stop_in  = 1'b0;
               val_in   = '0;
            end
            K_APPEND: begin
               scan_in = scan_ff + AW'(1);
               len_in  = len_ff + LW'(1);
               if (len_ff == LW'(1)) begin
                  type_in = rd_ff.ch;
               end
               if (len_ff == LW'(2)) begin
                  dec_in = (rd_ff.ch == CH_D);
               end
               if (len_ff >= LW'(4)) begin
                  if (!dec_ff) begin
                     val_in = {val_ff[27:0], hexd};
                  end else if ((len_ff == LW'(4)) && rd_ff.cls.minus) begin
                     neg_in = 1'b1;
                  end else if (rd_ff.cls.digit && !stop_ff) begin
                     val_in = {val_ff[28:0], 3'b000} + {val_ff[30:0], 1'b0}
                              + {28'd0, rd_ff.ch[3:0]};
                  end else begin
                     stop_in = 1'b1;
                  end
               end
            end
            K_TOKEN: begin
               scan_in = scan_ff + AW'(1);
               len_in  = '0;
               k_in    = 2'd0;
               val_in  = neg_ff ? (32'd0 - val_ff) : val_ff;
            end
            K_FAIL, K_FLUSH_FAIL: begin
               start_in = start_ff + AW'(1);
               scan_in  = start_ff + AW'(1);
               len_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mem[end_ff] <= head.item;
      end
      rd_ff <= mem[scan_ff];
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      dec_ff    <= dec_in;
      neg_ff    <= neg_in;
      stop_ff   <= stop_in;
      val_ff    <= val_in;
      k_ff      <= k_in;
      hold_b_ff <= hold_b_in;
      rsp_b_ff  <= rsp_b_in;
      rsp_l_ff  <= rsp_l_in;
      start_ff  <= start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         scan_ff   <= '0;
         end_ff    <= '0;
         len_ff    <= '0;
         esc_ff    <= 1'b0;
         eot_ff    <= 1'b0;
         cnt_ff    <= '0;
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scan_ff   <= scan_in;
         end_ff    <= end_in;
         len_ff    <= len_in;
         esc_ff    <= esc_in;
         eot_ff    <= eot_in;
         cnt_ff    <= cnt_in;
         hold_v_ff <= hold_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

endmodule

[bench/tb_bytecode_text_to_binary_core.sv]
`timescale 1ns / 1ps

module tb_bytecode_text_to_binary_core;
   import bt2b_pkg::*;

   localparam int TOKEN_MAX = 32;
   localparam int BYTE_CAP  = 32;
   localparam int SETTLE    = 20;

   typedef struct {
      logic [7:0] b;
      logic       last;
   } out_item_type;

   typedef struct {
      string text;
      bit    eot;
      bit    endian;
      string hex;
   } row_type;

   logic clock;
   logic reset;

   bt2b_req_if req_ch ();
   bt2b_rsp_if rsp_ch ();
   bt2b_csr_if csr_ch ();

   bytecode_text_to_binary_core #(.MAX_TOKEN(TOKEN_MAX)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [7:0]   tok_buf [TOKEN_MAX];
   int           tok_len;
   bit           esc_wait;
   bit           endian_sel;
   logic [7:0]   step_bytes [$];
   out_item_type expected_bytes [$];
   logic [7:0]   captured [$];
   logic [7:0]   seq [$];
   bit           calm;
   int           errors;
   int           n_req;
   int           n_rsp;
   int           n_writes;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("end of test: mismatches");
      $finish;
   end

   // translation predictor
   function automatic void put_byte(logic [7:0] b);
      if (step_bytes.size() < BYTE_CAP) step_bytes.push_back(b);
   endfunction

   function automatic void pack_token();
      logic [31:0] v;
      int          i;
      int          nb;
      int          sh;
      bit          neg;
      v   = '0;
      i   = 4;
      neg = 1'b0;
      if (tok_buf[2] == CH_D) begin
         if (i < tok_len && tok_buf[i] == CH_MINUS) begin
            neg = 1'b1;
            i++;
         end
         while (i < tok_len && tok_buf[i] >= CH_0 && tok_buf[i] <= CH_9) begin
            v = v * 32'd10 + 32'(tok_buf[i] - CH_0);
            i++;
         end
         if (neg) v = 32'd0 - v;
      end else begin
         for (; i < tok_len; i++) begin
            v = (v << 4) | 32'((tok_buf[i] <= CH_9) ? tok_buf[i] - CH_0
                                                    : tok_buf[i] - CH_A + 8'd10);
         end
      end
      nb = (tok_buf[1] == CH_B) ? 1 : (tok_buf[1] == CH_W) ? 2 : 4;
      for (int k = 0; k < nb; k++) begin
         sh = endian_sel ? 8 * (nb - 1 - k) : 8 * k;
         put_byte(8'(v >> sh));
      end
   endfunction

   function automatic void drop_candidate();
      logic [7:0] rest [$];
      for (int i = 1; i < tok_len && i < TOKEN_MAX; i++) rest.push_back(tok_buf[i]);
      tok_len = 0;
      put_byte(CH_LT);
      foreach (rest[i]) scan_char(rest[i]);
   endfunction

   function automatic void scan_char(logic [7:0] c);
      bit ok;
      int p;
      if (esc_wait) begin
         esc_wait = 1'b0;
         if (c == CH_LT || c == CH_BS) begin
            put_byte(c);
            return;
         end
         put_byte(CH_BS);
      end
      if (tok_len == 0) begin
         if (c == CH_LT) begin
            tok_buf[0] = c;
            tok_len = 1;
         end else if (c == CH_BS) begin
            esc_wait = 1'b1;
         end else begin
            put_byte(c);
         end
         return;
      end
      p = tok_len;
      if (p == 1) ok = (c == CH_B || c == CH_W || c == CH_L);
      else if (p == 2) ok = (c == CH_D || c == CH_H);
      else if (p == 3) ok = (c == CH_COLON);
      else begin
         if (c == CH_GT && p > 4) begin
            pack_token();
            tok_len = 0;
            return;
         end
         if (tok_buf[2] == CH_D) ok = (c >= CH_0 && c <= CH_9) || c == CH_MINUS;
         else ok = (c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_F);
         if (p + 1 > TOKEN_MAX - 1) ok = 1'b0;
      end
      if (ok && p < TOKEN_MAX) begin
         tok_buf[p] = c;
         tok_len = p + 1;
         return;
      end
      drop_candidate();
      scan_char(c);
   endfunction

   function automatic void predict_bytes(logic [7:0] c, bit eot);
      out_item_type e;
      step_bytes.delete();
      scan_char(c);
      if (eot) begin
         forever begin
            if (esc_wait) begin
               esc_wait = 1'b0;
               put_byte(CH_BS);
            end else if (tok_len > 0) begin
               drop_candidate();
            end else begin
               break;
            end
         end
      end
      foreach (step_bytes[k]) begin
         e.b    = step_bytes[k];
         e.last = (k == step_bytes.size() - 1);
         expected_bytes.push_back(e);
      end
   endfunction

   task automatic send_char(logic [7:0] c, bit eot);
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.text_char   <= c;
      req_ch.end_of_text <= eot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_bytes(c, eot);
      n_req++;
   endtask

   task automatic send_seq(bit eot_at_end);
      foreach (seq[i]) send_char(seq[i], eot_at_end && i == seq.size() - 1);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_endian(bit v);
      csr_ch.valid       <= 1'b1;
      csr_ch.endian_mode <= v;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      endian_sel = v;
      n_writes++;
   endtask

   function automatic logic [7:0] hex_char(int d);
      return (d < 10) ? CH_0 + 8'(d) : CH_A + 8'(d - 10);
   endfunction

   function automatic void add_digits(bit is_dec, int n);
      if (is_dec && $urandom_range(0, 3) == 0) seq.push_back(CH_MINUS);
      for (int i = 0; i < n; i++)
         seq.push_back(is_dec ? CH_0 + 8'($urandom_range(0, 9)) : hex_char($urandom_range(0, 15)));
   endfunction

   function automatic void add_token();
      bit dec;
      int t;
      dec = $urandom_range(0, 1);
      t   = $urandom_range(0, 2);
      seq.push_back(CH_LT);
      seq.push_back(t == 0 ? CH_B : t == 1 ? CH_W : CH_L);
      seq.push_back(dec ? CH_D : CH_H);
      seq.push_back(CH_COLON);
      add_digits(dec, $urandom_range(1, dec ? 11 : 9));
      seq.push_back(CH_GT);
   endfunction

   function automatic void make_random_seq();
      int r;
      int cut;
      seq.delete();
      r = $urandom_range(0, 99);
      if (r < 55) begin
         add_token();
      end else if (r < 65) begin
         seq.push_back(CH_BS);
         r = $urandom_range(0, 2);
         seq.push_back(r == 0 ? CH_LT : r == 1 ? CH_BS : 8'($urandom_range(0, 255)));
      end else if (r < 78) begin
         add_token();
         cut = $urandom_range(1, seq.size() - 1);
         while (seq.size() > cut) void'(seq.pop_back());
         seq.push_back(8'($urandom_range(0, 255)));
      end else if (r < 82) begin
         seq = {CH_LT, CH_L, CH_H, CH_COLON};
         add_digits(1'b0, $urandom_range(26, 30));
         seq.push_back(CH_GT);
      end else begin
         repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
      end
   end

   always @(posedge clock) begin
      out_item_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_rsp++;
         captured.push_back(rsp_ch.out_byte);
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual %02h last %b",
                     $time, rsp_ch.out_byte, rsp_ch.last_byte);
            errors++;
         end else begin
            e = expected_bytes.pop_front();
            if (e.b !== rsp_ch.out_byte) begin
               $display("%0t: out_byte expected %02h actual %02h", $time, e.b, rsp_ch.out_byte);
               errors++;
            end
            if (e.last !== rsp_ch.last_byte) begin
               $display("%0t: last_byte expected %b actual %b", $time, e.last,
                        rsp_ch.last_byte);
               errors++;
            end
         end
      end
   end

   initial begin
      row_type rows [$];
      string   got;
      int      limit;
      errors   = 0;
      n_req    = 0;
      n_rsp    = 0;
      n_writes = 0;
      calm     = 1'b0;
      tok_len  = 0;
      esc_wait = 1'b0;
      endian_sel = 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.text_char   <= '0;
      req_ch.end_of_text <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.endian_mode <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = '{
         '{"<bd:42>",          1'b0, 1'b0, "2a"},
         '{"<bd:-1>",          1'b0, 1'b0, "ff"},
         '{"<wh:1234>",        1'b0, 1'b0, "3412"},
         '{"<wh:1234>",        1'b0, 1'b1, "1234"},
         '{"<lh:deadbeef>",    1'b0, 1'b1, "deadbeef"},
         '{"<lh:ffffffff>",    1'b0, 1'b1, "ffffffff"},
         '{"<lh:deadbeef>",    1'b0, 1'b0, "efbeadde"},
         '{"<ld:4294967296>",  1'b0, 1'b0, "00000000"},
         '{"<ld:-2147483648>", 1'b0, 1'b0, "00000080"},
         '{"<bd:--5>",         1'b0, 1'b0, "00"},
         '{"<bd:>",            1'b0, 1'b0, "3c62643a3e"},
         '{"<fd:1>",           1'b0, 1'b0, "3c66643a313e"},
         '{"<bl:1>",           1'b0, 1'b0, "3c626c3a313e"},
         '{"<bo:1>",           1'b0, 1'b0, "3c626f3a313e"},
         '{"\\<",              1'b0, 1'b0, "3c"},
         '{"\\\\",             1'b0, 1'b0, "5c"},
         '{"\\a",              1'b0, 1'b0, "5c61"},
         '{"<bd:-",            1'b1, 1'b0, "3c62643a2d"},
         '{"\\",               1'b1, 1'b0, "5c"},
         '{"<wd:12a>",         1'b0, 1'b0, ""},
         '{"a<<bh:7f>",        1'b0, 1'b1, ""},
         '{"<lh:0123456789abcdef0123456789ab>", 1'b0, 1'b0, ""},
         '{"<<\\<wh:\\",       1'b1, 1'b0, ""}
      };

      write_endian(1'b0);
      foreach (rows[r]) begin
         if (rows[r].endian != endian_sel) write_endian(rows[r].endian);
         seq.delete();
         for (int i = 0; i < rows[r].text.len(); i++) seq.push_back(rows[r].text[i]);
         captured.delete();
         send_seq(rows[r].eot);
         drain();
         if (rows[r].hex != "") begin
            got = "";
            foreach (captured[i]) got = $sformatf("%s%02h", got, captured[i]);
            if (got != rows[r].hex) begin
               $display("%0t: row %0d expected %s actual %s", $time, r, rows[r].hex, got);
               errors++;
            end
         end
      end

      while (n_req < 560) begin
         calm = (n_req >= 250 && n_req < 350);
         make_random_seq();
         send_seq($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 39) == 0) begin
            drain();
            write_endian(~endian_sel);
         end
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      limit = 0;
      while (expected_bytes.size() != 0 && limit < 100000) begin
         @(posedge clock);
         limit++;
      end
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d characters, %0d bytes out, %0d endian writes",
               n_req, n_rsp, n_writes);
      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d bytes never seen", errors, expected_bytes.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
